FILE: design/pdmd_pkg.sv
// ----------------------------------------------------------------------------
// pdmd_pkg
// shared widths, register indexes and the drive output function
// ----------------------------------------------------------------------------
package pdmd_pkg;

	localparam int CfgIdxW = 4;
	localparam int CfgDataW = 17;
	localparam int ErrW = 17;
	localparam int IntW = 20;
	localparam int CtlW = 37;
	localparam int DrvW = 53;
	localparam int FracW = 24;

	localparam logic [CfgIdxW-1:0] REG_SETPOINT = 4'd0;
	localparam logic [CfgIdxW-1:0] REG_GAIN_P   = 4'd1;
	localparam logic [CfgIdxW-1:0] REG_GAIN_I   = 4'd2;
	localparam logic [CfgIdxW-1:0] REG_GAIN_D   = 4'd3;
	localparam logic [CfgIdxW-1:0] REG_SCALE1   = 4'd4;
	localparam logic [CfgIdxW-1:0] REG_SCALE2   = 4'd5;
	localparam logic [CfgIdxW-1:0] REG_UPPER    = 4'd6;
	localparam logic [CfgIdxW-1:0] REG_LOWER    = 4'd7;

	localparam logic        OP_UPDATE = 1'b0;
	localparam logic signed [IntW:0] WINDUP_POS = 21'sd307200;
	localparam logic signed [IntW:0] WINDUP_NEG = -21'sd307200;
	localparam logic [15:0] SPEED_MAX = 16'hFFFF;

	typedef struct packed {
		logic        fwd;
		logic [15:0] speed;
	} drive_t;

	// truncate a clamped q.24 drive value toward zero, take magnitude and sign
	function automatic drive_t drive_out(input logic signed [DrvW-1:0] v);
		logic signed [DrvW-FracW-1:0] q;
		logic [DrvW-FracW-1:0] mag;
		drive_t d;
		q = v[DrvW-1:FracW];
		if (v[DrvW-1] && (v[FracW-1:0] != '0))
			q = q + 29'sd1;
		mag = q[DrvW-FracW-1] ? 29'(-q) : 29'(q);
		d.fwd = ~v[DrvW-1];
		d.speed = (mag > 29'(SPEED_MAX)) ? SPEED_MAX : mag[15:0];
		return d;
	endfunction

endpackage

FILE: design/pid_dual_motor_drive.sv
// ----------------------------------------------------------------------------
// pid_dual_motor_drive
// pid controller with anti-windup clamp driving two motors, bit-serial math
// ----------------------------------------------------------------------------
// an accepted update runs the three gain products in the first shift-add loop,
// then the two scale products in the second, then the clamp and the output load;
// a new transaction is taken only once the block is idle again after that load
// clear transactions finish in the accept cycle and give no result
// reset: async active low; integral and last error zero, registers at defaults
module pid_dual_motor_drive
	import pdmd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic signed [15:0]  measured,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         speed_one,
	output logic                forward_one,
	output logic [15:0]         speed_two,
	output logic                forward_two
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL1  = 3'd1;
	localparam logic [2:0] S_MUL2  = 3'd2;
	localparam logic [2:0] S_CLAMP = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	// configuration registers
	logic signed [15:0] setpoint_q, gain_p_q, gain_i_q, gain_d_q, scale1_q, scale2_q;
	logic signed [16:0] upper_q, lower_q;

	// controller state
	logic signed [IntW-1:0] integral_q;
	logic signed [ErrW-1:0] last_q;

	// sequencer
	logic [2:0] state_q;
	logic [3:0] cnt_q;

	// first loop: multiplicands shift left, gain bits shift out at the bottom
	logic [CtlW-1:0] ma_q, mb_q, mc_q, acc_q;
	logic [15:0] ga_q, gb_q, gc_q;
	// second loop: control value against both scales
	logic [DrvW-1:0] mx_q, acc1_q, acc2_q;
	logic [15:0] s1_q, s2_q;

	logic accept;
	logic out_load;
	logic signed [ErrW-1:0] err;
	logic signed [IntW:0] isum;
	logic signed [IntW-1:0] isum_cl;
	logic signed [ErrW:0] dif;
	logic [CtlW-1:0] add1, acc_nx;
	logic [DrvW-1:0] add_a, add_b;
	logic [DrvW-1:0] up_ext, lo_ext, v1c, v2c;
	drive_t d1, d2;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	// result register loads once the previous result has left
	assign out_load = (state_q == S_OUT) && (!out_valid || out_ready);

	always_comb begin
		err = ErrW'(setpoint_q) - ErrW'(measured);
		isum = (IntW+1)'(integral_q) + (IntW+1)'(err);
		if (isum > WINDUP_POS)
			isum_cl = WINDUP_POS[IntW-1:0];
		else if (isum < WINDUP_NEG)
			isum_cl = WINDUP_NEG[IntW-1:0];
		else
			isum_cl = isum[IntW-1:0];
		dif = (ErrW+1)'(last_q) - (ErrW+1)'(err);
	end

	// one gain or scale bit per cycle; the top bit carries negative weight
	always_comb begin
		add1 = (ga_q[0] ? ma_q : '0) + (gb_q[0] ? mb_q : '0) + (gc_q[0] ? mc_q : '0);
		acc_nx = (cnt_q == 4'd15) ? acc_q - add1 : acc_q + add1;
		add_a = s1_q[0] ? mx_q : '0;
		add_b = s2_q[0] ? mx_q : '0;
	end

	// limits moved to q.24 and clamp, upper test first
	always_comb begin
		up_ext = {{(DrvW-17-FracW){upper_q[16]}}, upper_q, {FracW{1'b0}}};
		lo_ext = {{(DrvW-17-FracW){lower_q[16]}}, lower_q, {FracW{1'b0}}};
		v1c = acc1_q;
		if ($signed(v1c) >= $signed(up_ext))
			v1c = up_ext;
		if ($signed(v1c) <= $signed(lo_ext))
			v1c = lo_ext;
		v2c = acc2_q;
		if ($signed(v2c) >= $signed(up_ext))
			v2c = up_ext;
		if ($signed(v2c) <= $signed(lo_ext))
			v2c = lo_ext;
		d1 = drive_out(acc1_q);
		d2 = drive_out(acc2_q);
	end

	// configuration writes, indexes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			scale1_q <= 16'sd256;
			scale2_q <= 16'sd256;
			upper_q <= 17'sd65535;
			lower_q <= -17'sd65535;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SETPOINT: setpoint_q <= cfg_data[15:0];
				REG_GAIN_P:   gain_p_q <= cfg_data[15:0];
				REG_GAIN_I:   gain_i_q <= cfg_data[15:0];
				REG_GAIN_D:   gain_d_q <= cfg_data[15:0];
				REG_SCALE1:   scale1_q <= cfg_data[15:0];
				REG_SCALE2:   scale2_q <= cfg_data[15:0];
				REG_UPPER:    upper_q <= cfg_data;
				REG_LOWER:    lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			integral_q <= '0;
			last_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_load)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (operation == OP_UPDATE) begin
							integral_q <= isum_cl;
							last_q <= err;
							cnt_q <= '0;
							state_q <= S_MUL1;
						end else begin
							// clear transaction
							integral_q <= '0;
							last_q <= '0;
						end
					end
				end
				S_MUL1: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15)
						state_q <= S_MUL2;
				end
				S_MUL2: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15)
						state_q <= S_CLAMP;
				end
				S_CLAMP: state_q <= S_OUT;
				S_OUT: begin
					// hold here while the previous result is still pending
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath shift registers and accumulators
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ma_q <= CtlW'(err);
				mb_q <= CtlW'(isum_cl);
				mc_q <= CtlW'(dif);
				ga_q <= gain_p_q;
				gb_q <= gain_i_q;
				gc_q <= gain_d_q;
				acc_q <= '0;
			end
			S_MUL1: begin
				ma_q <= ma_q << 1;
				mb_q <= mb_q << 1;
				mc_q <= mc_q << 1;
				ga_q <= ga_q >> 1;
				gb_q <= gb_q >> 1;
				gc_q <= gc_q >> 1;
				acc_q <= acc_nx;
				if (cnt_q == 4'd15) begin
					mx_q <= DrvW'($signed(acc_nx));
					s1_q <= scale1_q;
					s2_q <= scale2_q;
					acc1_q <= '0;
					acc2_q <= '0;
				end
			end
			S_MUL2: begin
				mx_q <= mx_q << 1;
				s1_q <= s1_q >> 1;
				s2_q <= s2_q >> 1;
				acc1_q <= (cnt_q == 4'd15) ? acc1_q - add_a : acc1_q + add_a;
				acc2_q <= (cnt_q == 4'd15) ? acc2_q - add_b : acc2_q + add_b;
			end
			S_CLAMP: begin
				acc1_q <= v1c;
				acc2_q <= v2c;
			end
			S_OUT: begin
				if (out_load) begin
					speed_one <= d1.speed;
					forward_one <= d1.fwd;
					speed_two <= d2.speed;
					forward_two <= d2.fwd;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: tb/tb_pid_dual_motor_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_dual_motor_drive
// randomized valid/ready test of the dual motor pid drive: a behavioral pid
// model predicts speed and direction of both motors for every update, the
// monitor compares each output transaction with the oldest prediction
// ----------------------------------------------------------------------------
module tb_pid_dual_motor_drive;
	import pdmd_pkg::*;

	typedef struct packed {
		logic        op;
		logic [15:0] meas;
	} sample_t;

	typedef struct packed {
		logic [15:0] spd1;
		logic        fwd1;
		logic [15:0] spd2;
		logic        fwd2;
	} motor_cmd_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                operation = 1'b0;
	logic signed [15:0]  measured = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [15:0]         speed_one;
	logic                forward_one;
	logic [15:0]         speed_two;
	logic                forward_two;

	pid_dual_motor_drive uut (.*);

	always #5 clk = ~clk;

	// model state: configuration plus integral and last error
	longint m_set, m_kp, m_ki, m_kd, m_sc1, m_sc2, m_hi, m_lo;
	longint m_integ, m_last;

	sample_t    sample_q[$];
	motor_cmd_t cmd_q[$];
	bit         failed = 1'b0;
	bit         no_idle = 1'b0;
	int         src_gap = 0;
	int         snk_gap = 0;
	longint     cycles = 0;

	function automatic void motor_drive(input longint ctl, input longint sc,
			output logic [15:0] spd, output logic fwd);
		longint v, q, mag;
		v = ctl * sc;
		if (v >= m_hi * 64'sd16777216)
			v = m_hi * 64'sd16777216;
		if (v <= m_lo * 64'sd16777216)
			v = m_lo * 64'sd16777216;
		q = v / 64'sd16777216;
		mag = q < 0 ? -q : q;
		if (mag > 65535)
			mag = 65535;
		spd = mag[15:0];
		fwd = v < 0 ? 1'b0 : 1'b1;
	endfunction

	// advance the pid state for one transaction and, for an update, queue its motor command
	function automatic void pid_advance(input sample_t s);
		longint err, ctl;
		motor_cmd_t c;
		if (s.op != OP_UPDATE) begin
			m_integ = 0;
			m_last = 0;
			return;
		end
		err = m_set - longint'($signed(s.meas));
		m_integ += err;
		if (m_integ > 307200)
			m_integ = 307200;
		if (m_integ < -307200)
			m_integ = -307200;
		ctl = err * m_kp + m_integ * m_ki + (m_last - err) * m_kd;
		motor_drive(ctl, m_sc1, c.spd1, c.fwd1);
		motor_drive(ctl, m_sc2, c.spd2, c.fwd2);
		m_last = err;
		cmd_q.push_back(c);
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CfgDataW-1:0];
		case (idx)
			REG_SETPOINT: m_set = longint'($signed(val[15:0]));
			REG_GAIN_P:   m_kp = longint'($signed(val[15:0]));
			REG_GAIN_I:   m_ki = longint'($signed(val[15:0]));
			REG_GAIN_D:   m_kd = longint'($signed(val[15:0]));
			REG_SCALE1:   m_sc1 = longint'($signed(val[15:0]));
			REG_SCALE2:   m_sc2 = longint'($signed(val[15:0]));
			REG_UPPER:    m_hi = longint'($signed(val[16:0]));
			REG_LOWER:    m_lo = longint'($signed(val[16:0]));
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for all predictions to drain, then let the block settle
	task automatic drain();
		while (sample_q.size() != 0 || in_valid || cmd_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic longint rnd16();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return 32767;
			2: return longint'($urandom_range(0, 512)) - 256;
			default: return longint'($signed(16'($urandom())));
		endcase
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		s.op = ($urandom_range(0, 15) == 0) ? ~OP_UPDATE : OP_UPDATE;
		s.meas = 16'(rnd16());
		return s;
	endfunction

	// pick a random full register set; limits ordered upper above lower
	task automatic rand_config();
		longint a, b, t;
		write_reg(REG_SETPOINT, rnd16());
		write_reg(REG_GAIN_P, rnd16());
		write_reg(REG_GAIN_I, rnd16());
		write_reg(REG_GAIN_D, rnd16());
		write_reg(REG_SCALE1, rnd16());
		write_reg(REG_SCALE2, rnd16());
		a = longint'($urandom_range(0, 131070)) - 65535;
		b = longint'($urandom_range(0, 131070)) - 65535;
		if (a < b) begin
			t = a; a = b; b = t;
		end
		if (a == b)
			a = b + 1;
		write_reg(REG_UPPER, a > 65535 ? 65535 : a);
		write_reg(REG_LOWER, a > 65535 ? b - 1 : b);
	endtask

	task automatic push_meas(input logic op, input longint v);
		sample_t s;
		s.op = op;
		s.meas = 16'(v);
		sample_q.push_back(s);
	endtask

	// source side: one transaction at a time, random gaps
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			pid_advance(sample_t'{operation, measured});
		end
		if (!in_valid || in_ready) begin
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				in_valid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				sample_t s;
				s = sample_q.pop_front();
				in_valid <= 1'b1;
				operation <= s.op;
				measured <= s.meas;
				if (!no_idle && $urandom_range(0, 3) == 0)
					src_gap <= $urandom_range(1, 11);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// sink side: random stall bursts on out_ready, compare each transaction
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			motor_cmd_t c;
			if (cmd_q.size() == 0) begin
				$display("%0t: unexpected transaction spd1=%0d spd2=%0d", $time,
					speed_one, speed_two);
				failed = 1'b1;
			end else begin
				c = cmd_q.pop_front();
				if (speed_one !== c.spd1) begin
					$display("%0t: speed_one expected %0d actual %0d", $time, c.spd1, speed_one);
					failed = 1'b1;
				end
				if (forward_one !== c.fwd1) begin
					$display("%0t: forward_one expected %0b actual %0b", $time, c.fwd1,
						forward_one);
					failed = 1'b1;
				end
				if (speed_two !== c.spd2) begin
					$display("%0t: speed_two expected %0d actual %0d", $time, c.spd2, speed_two);
					failed = 1'b1;
				end
				if (forward_two !== c.fwd2) begin
					$display("%0t: forward_two expected %0b actual %0b", $time, c.fwd2,
						forward_two);
					failed = 1'b1;
				end
			end
		end
		if (snk_gap > 0) begin
			snk_gap <= snk_gap - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 5) == 0)
				snk_gap <= $urandom_range(1, 11);
		end
	end

	// watchdog: reports failure and stops if the 719 items and their stalls overrun the limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		m_set = 0; m_kp = 0; m_ki = 0; m_kd = 0;
		m_sc1 = 256; m_sc2 = 256; m_hi = 65535; m_lo = -65535;
		m_integ = 0; m_last = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: defaults, then unit gains with extreme samples
		push_meas(OP_UPDATE, 0);
		push_meas(OP_UPDATE, 32767);
		drain();
		write_reg(REG_GAIN_P, 256);
		write_reg(REG_GAIN_I, 256);
		write_reg(REG_GAIN_D, 256);
		write_reg(REG_SETPOINT, 32767);
		// repeated large errors drive the integral into its clamp
		for (int i = 0; i < 6; i++)
			push_meas(OP_UPDATE, -32768);
		push_meas(~OP_UPDATE, 1234);
		push_meas(OP_UPDATE, -32768);
		drain();
		// full scale to limits: upper limit 65535 and lower limit -65536 with magnitude saturation
		write_reg(REG_SETPOINT, -32768);
		write_reg(REG_SCALE1, 32767);
		write_reg(REG_SCALE2, -32768);
		write_reg(REG_GAIN_P, -32768);
		write_reg(REG_LOWER, -65536);
		for (int i = 0; i < 3; i++)
			push_meas(OP_UPDATE, 32767);
		drain();
		// tiny negative drive truncates to speed 0 with forward 0
		write_reg(REG_GAIN_P, 1);
		write_reg(REG_GAIN_I, 0);
		write_reg(REG_GAIN_D, 0);
		write_reg(REG_SCALE1, 1);
		write_reg(REG_SCALE2, 1);
		write_reg(REG_SETPOINT, 0);
		push_meas(~OP_UPDATE, 0);
		push_meas(OP_UPDATE, 1);
		push_meas(OP_UPDATE, -1);
		drain();
		// inverted limits: lower limit wins
		write_reg(REG_UPPER, -100);
		write_reg(REG_LOWER, 100);
		write_reg(REG_GAIN_P, 32767);
		write_reg(REG_SCALE1, 256);
		write_reg(REG_SCALE2, -256);
		push_meas(OP_UPDATE, 300);
		push_meas(OP_UPDATE, -300);
		// out-of-range register index is ignored
		drain();
		write_reg(4'd15, 17'h1ffff);
		write_reg(REG_UPPER, 65535);
		write_reg(REG_LOWER, -65535);
		push_meas(OP_UPDATE, 77);
		drain();

		// random phases, mostly updates with occasional clears
		for (int p = 0; p < 14; p++) begin
			rand_config();
			if (p == 13)
				no_idle = 1'b1;
			for (int i = 0; i < 50; i++)
				sample_q.push_back(rand_sample());
			drain();
		end

		if (!failed)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
design/pdmd_pkg.sv
design/pid_dual_motor_drive.sv
tb/tb_pid_dual_motor_drive.sv
